// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression must hold at every clock edge outside reset
`define UPD_ASSERT(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define UPD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define UPD_ASSERT(label, clk, rst, expr)
`define UPD_ASSERT_IMP(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/upd_pkg.sv =====
// ---------------------------------------------------------------------------
// upd_pkg
// shared types, constants and helpers of the url percent decoder
// ---------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_TERM = 2'd1,
    KIND_FULL = 2'd2
  } kind_t;

  // work for the back end: up to three candidate bytes, then an optional end
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic            is_end;
  } plan_t;

  typedef struct packed {
    logic              full;
    logic [QUEUE_AW:0] level;
  } queue_status_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  // letters have low nibble 1..6, so adding 9 gives 10..15
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/url_percent_decoder.sv =====
// ---------------------------------------------------------------------------
// url_percent_decoder
// streaming form-urlencoded decoder with output capacity limit
// ---------------------------------------------------------------------------
// usage: source characters enter on in_valid/in_ready, one per transfer, and
// a transfer with end_of_string high closes the string. decoded bytes leave
// on out_valid/out_ready with result_kind and last; the end item gives one
// final result (terminator, or end mark when capacity is used up) with last.
// output_capacity is written on cfg_valid/cfg_ready between strings.
// path: the input transfer writes the plan queue, and out_valid rises once
// the output register is later loaded from the queue head.
// throughput: one input per cycle while each item yields at most one result
// and out_ready stays high; the back end walks one candidate byte per cycle
// while the output is not stalled, so a malformed escape that flushes held
// characters takes one slot per flushed byte there, up to three bytes,
// absorbed by the four-entry plan queue. dropped bytes past capacity also
// take their slot. reset clears held escape state, byte count, queue and
// out_valid and sets the capacity to all ones. when the receiver stalls the
// output register holds, the queue fills, and in_ready drops once it is full.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module url_percent_decoder #(
  parameter int CAPACITY_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [upd_pkg::CFG_DATA_W-1:0]    output_capacity,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [7:0]                        in_byte,
  input  wire                               end_of_string,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [7:0]                        out_byte,
  output upd_pkg::kind_t                    result_kind,
  output logic                              last
);
  import upd_pkg::*;

  localparam int EXT_W = (CAPACITY_BITS > CFG_DATA_W) ? CAPACITY_BITS : CFG_DATA_W;

  logic [CAPACITY_BITS-1:0] capacity;
  logic [EXT_W-1:0]         cap_ext;
  logic [CAPACITY_BITS-1:0] written_count;
  queue_status_t            q_status;
  plan_t                    plan;
  plan_t                    head_plan;
  logic                     push;
  logic                     pop;
  logic                     head_valid;

  assign cfg_ready = 1'b1;
  assign cap_ext   = EXT_W'(output_capacity);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '1;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cap_ext[CAPACITY_BITS-1:0];
    end
  end

  upd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_string(end_of_string),
    .q_status     (q_status),
    .push         (push),
    .plan         (plan)
  );

  upd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_plan (plan),
    .pop       (pop),
    .head_valid(head_valid),
    .head_plan (head_plan),
    .status    (q_status)
  );

  upd_back #(
    .CAPACITY_BITS(CAPACITY_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_plan    (head_plan),
    .pop          (pop),
    .capacity     (capacity),
    .written_count(written_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .result_kind  (result_kind),
    .last         (last)
  );

  // last marks exactly the terminator or end-mark result
  `UPD_ASSERT_IMP(a_last_kind, clk, rst, out_valid, last == (result_kind != KIND_DATA))
  `UPD_ASSERT_IMP(a_kind_legal, clk, rst, out_valid, result_kind <= KIND_FULL)
  // the byte count restarts once the end result is loaded
  `UPD_ASSERT_IMP(a_count_cleared, clk, rst, out_valid && last, written_count == '0)
  // a pending data byte has been counted
  `UPD_ASSERT_IMP(a_data_counted, clk, rst, out_valid && !last, written_count != '0)
  `UPD_ASSERT(a_queue_level, clk, rst, q_status.level <= (QUEUE_AW+1)'(QUEUE_DEPTH))

endmodule

`default_nettype wire

// ===== src/upd_front.sv =====
// ---------------------------------------------------------------------------
// upd_front
// accepts source characters, tracks held escape state, builds output plans
// ---------------------------------------------------------------------------
`default_nettype none

module upd_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [7:0]            in_byte,
  input  wire                   end_of_string,
  input  upd_pkg::queue_status_t q_status,
  output logic                  push,
  output upd_pkg::plan_t        plan
);
  import upd_pkg::*;

  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic [7:0] held_first;
  logic [7:0] held_first_next;

  logic       fresh_hold;
  logic [7:0] fresh_byte;
  logic [1:0] fresh_n;
  logic       accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (plan.count != 2'd0 || plan.is_end);

  // what a character does when nothing is held
  always_comb begin
    fresh_hold = (in_byte == CH_PERCENT);
    fresh_byte = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
    fresh_n    = fresh_hold ? 2'd0 : 2'd1;
  end

  always_comb begin
    plan            = '0;
    held_count_next = held_count;
    held_first_next = held_first;
    if (end_of_string) begin
      plan.is_end     = 1'b1;
      plan.bytes[0]   = CH_PERCENT;
      plan.bytes[1]   = held_first;
      plan.count      = (held_count == 2'd3) ? 2'd2 : held_count;
      held_count_next = 2'd0;
    end else begin
      case (held_count)
        2'd0: begin
          plan.bytes[0]   = fresh_byte;
          plan.count      = fresh_n;
          held_count_next = fresh_hold ? 2'd1 : 2'd0;
        end
        2'd1: begin
          if (is_hex(in_byte)) begin
            held_count_next = 2'd2;
            held_first_next = in_byte;
          end else begin
            plan.bytes[0]   = CH_PERCENT;
            plan.bytes[1]   = fresh_byte;
            plan.count      = 2'd1 + fresh_n;
            held_count_next = fresh_hold ? 2'd1 : 2'd0;
          end
        end
        default: begin
          if (is_hex(in_byte) && is_hex(held_first)) begin
            plan.bytes[0]   = {hex_val(held_first), hex_val(in_byte)};
            plan.count      = 2'd1;
            held_count_next = 2'd0;
          end else begin
            // malformed escape: flush both held chars, then rescan this one
            plan.bytes[0]   = CH_PERCENT;
            plan.bytes[1]   = held_first;
            plan.bytes[2]   = fresh_byte;
            plan.count      = 2'd2 + fresh_n;
            held_count_next = fresh_hold ? 2'd1 : 2'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      held_first <= 8'd0;
    end else if (accept) begin
      held_count <= held_count_next;
      held_first <= held_first_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/upd_queue.sv =====
// ---------------------------------------------------------------------------
// upd_queue
// short plan queue decoupling the front end from the back end
// ---------------------------------------------------------------------------
`default_nettype none

module upd_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  upd_pkg::plan_t         push_plan,
  input  wire                    pop,
  output logic                   head_valid,
  output upd_pkg::plan_t         head_plan,
  output upd_pkg::queue_status_t status
);
  import upd_pkg::*;

  plan_t               entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   level;
  logic                do_push;
  logic                do_pop;

  assign status.level = level;
  assign status.full  = (level == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid   = (level != '0);
  assign head_plan    = entries[rd_ptr];

  assign do_push = push && !status.full;
  assign do_pop  = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_plan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/upd_back.sv =====
// ---------------------------------------------------------------------------
// upd_back
// walks queued plans one byte per cycle unless the output stalls, applies capacity, drives results
// ---------------------------------------------------------------------------
`default_nettype none

module upd_back #(
  parameter int CAPACITY_BITS = 16
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      head_valid,
  input  upd_pkg::plan_t           head_plan,
  output logic                     pop,
  input  wire  [CAPACITY_BITS-1:0] capacity,
  output logic [CAPACITY_BITS-1:0] written_count,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [7:0]               out_byte,
  output upd_pkg::kind_t           result_kind,
  output logic                     last
);
  import upd_pkg::*;

  logic [1:0]               idx;
  logic [1:0]               idx_next;
  logic [CAPACITY_BITS-1:0] written_count_next;
  logic                     adv;
  logic                     is_data;
  logic                     fits;
  logic                     emit;
  logic [7:0]               emit_byte;
  kind_t                    emit_kind;
  logic                     emit_last;

  assign adv     = head_valid && (!out_valid || out_ready);
  assign is_data = (idx < head_plan.count);
  assign fits    = (written_count < capacity);

  always_comb begin
    idx_next           = idx;
    written_count_next = written_count;
    pop                = 1'b0;
    emit               = 1'b0;
    emit_byte          = 8'd0;
    emit_kind          = KIND_DATA;
    emit_last          = 1'b0;
    if (adv) begin
      if (is_data) begin
        // a byte past capacity is dropped but still uses its slot
        emit      = fits;
        emit_byte = head_plan.bytes[idx];
        if (fits) begin
          written_count_next = written_count + 1'b1;
        end
        if ({1'b0, idx} + 3'd1 == {1'b0, head_plan.count} && !head_plan.is_end) begin
          pop      = 1'b1;
          idx_next = 2'd0;
        end else begin
          idx_next = idx + 2'd1;
        end
      end else begin
        emit               = 1'b1;
        emit_kind          = fits ? KIND_TERM : KIND_FULL;
        emit_last          = 1'b1;
        written_count_next = '0;
        pop                = 1'b1;
        idx_next           = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx           <= 2'd0;
      written_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      idx           <= idx_next;
      written_count <= written_count_next;
      if (!out_valid || out_ready) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= emit_byte;
      result_kind <= emit_kind;
      last        <= emit_last;
    end
  end

endmodule

`default_nettype wire

// ===== tb/url_decode_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// url_decode_checker
// watches the capacity, character and result channels of the url percent
// decoder, keeps its own decoder state, predicts every result of each
// accepted character and compares each result transfer field by field
// ---------------------------------------------------------------------------
module url_decode_checker #(
  parameter int CAP_BITS = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_valid,
  input  wire                            cfg_ready,
  input  wire  [upd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                            in_valid,
  input  wire                            in_ready,
  input  wire  [7:0]                     in_byte,
  input  wire                            end_of_string,
  input  wire                            out_valid,
  input  wire                            out_ready,
  input  wire  [7:0]                     out_byte,
  input  upd_pkg::kind_t                 result_kind,
  input  wire                            last,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);

  import upd_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    kind_t      kind;
    logic       fin;
  } decoded_t;

  decoded_t            decoded_q[$];
  logic [CAP_BITS-1:0] cap_reg;
  logic [CAP_BITS-1:0] out_count;
  logic [1:0]          held_n;
  logic [7:0]          held_digit;
  int                  errors = 0;
  int                  results_seen = 0;
  int                  waiting = 0;

  assign fail_count = errors;
  assign pending    = waiting;
  assign checked    = results_seen;

  function automatic int digit_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
    return -1;
  endfunction

  // bytes past the capacity are dropped without a result
  task automatic emit(input logic [7:0] v);
    decoded_t r;
    if (out_count >= cap_reg) return;
    out_count = out_count + 1'b1;
    r.value = v;
    r.kind  = KIND_DATA;
    r.fin   = 1'b0;
    decoded_q.push_back(r);
  endtask

  task automatic take_char(input logic [7:0] c);
    if (c == CH_PERCENT) begin
      held_n = 2'd1;
    end else if (c == CH_PLUS) begin
      emit(CH_SPACE);
    end else begin
      emit(c);
    end
  endtask

  // a broken escape goes out literally
  task automatic release_held();
    if (held_n >= 2'd1) emit(CH_PERCENT);
    if (held_n >= 2'd2) emit(held_digit);
    held_n = 2'd0;
  endtask

  task automatic decode_step(input logic [7:0] c, input logic fin);
    decoded_t r;
    int       lo;
    int       hi;
    if (fin) begin
      release_held();
      r.value = 8'h00;
      r.kind  = (out_count < cap_reg) ? KIND_TERM : KIND_FULL;
      r.fin   = 1'b1;
      decoded_q.push_back(r);
      held_n    = 2'd0;
      out_count = '0;
    end else if (held_n == 2'd0) begin
      take_char(c);
    end else if (held_n == 2'd1) begin
      if (digit_of(c) >= 0) begin
        held_digit = c;
        held_n     = 2'd2;
      end else begin
        release_held();
        take_char(c);
      end
    end else begin
      lo = digit_of(c);
      hi = digit_of(held_digit);
      if (lo >= 0 && hi >= 0) begin
        held_n = 2'd0;
        emit(8'((hi << 4) | lo));
      end else begin
        release_held();
        take_char(c);
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    decoded_t exp_r;
    if (rst) begin
      cap_reg    = '1;
      out_count  = '0;
      held_n     = 2'd0;
      held_digit = 8'h00;
      decoded_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) cap_reg = CAP_BITS'(cfg_data);
      // predictions first, a result never leaves in its own input cycle
      if (in_valid && in_ready) decode_step(in_byte, end_of_string);
      if (out_valid && out_ready) begin
        results_seen++;
        if (decoded_q.size() == 0) begin
          $display("%0t: expected no result, actual byte %02h kind %0d last %0b",
                   $time, out_byte, result_kind, last);
          errors++;
        end else begin
          exp_r = decoded_q.pop_front();
          if (out_byte !== exp_r.value) begin
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, exp_r.value, out_byte);
            errors++;
          end
          if (result_kind !== exp_r.kind) begin
            $display("%0t: result_kind expected %0d actual %0d",
                     $time, exp_r.kind, result_kind);
            errors++;
          end
          if (last !== exp_r.fin) begin
            $display("%0t: last expected %0b actual %0b", $time, exp_r.fin, last);
            errors++;
          end
        end
      end
    end
    waiting = decoded_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// drives the url percent decoder with directed escapes, then random strings
// of well-formed and broken escapes under changing output capacities, with
// random gaps and stalls on both channels; the checker beside the block
// predicts and compares, this module gives the verdict
// ---------------------------------------------------------------------------
module tb_top;

  import upd_pkg::*;

  localparam int CAP_BITS     = 16;
  localparam int SETTLE       = 24;
  localparam int RANDOM_ITEMS = 280;
  localparam int HOLD_CYCLES  = 80;
  localparam int LIMIT        = 400000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_DATA_W-1:0] cfg_capacity;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_byte;
  logic                  end_of_string;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_byte;
  kind_t                 result_kind;
  logic                  last;

  int   fail_count;
  int   pending;
  int   checked;
  int   sent = 0;
  int   strings = 0;
  int   cfg_writes = 0;
  int   cycles = 0;
  logic hold_req = 1'b0;
  logic gapless = 1'b0;

  url_percent_decoder #(
    .CAPACITY_BITS(CAP_BITS)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .output_capacity (cfg_capacity),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .end_of_string   (end_of_string),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .result_kind     (result_kind),
    .last            (last)
  );

  url_decode_checker #(
    .CAP_BITS(CAP_BITS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_capacity),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .result_kind   (result_kind),
    .last          (last),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic int pick_gap(input logic no_idle);
    if (no_idle) return 0;
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return int'($urandom_range(1, 3));
      default: return int'($urandom_range(0, 14));
    endcase
  endfunction

  function automatic logic [7:0] hex_char();
    int d;
    d = int'($urandom_range(0, 21));
    if (d < 10) return 8'(8'h30 + d);
    if (d < 16) return 8'(8'h61 + d - 10);
    return 8'(8'h41 + d - 16);
  endfunction

  // includes the bytes just outside the hex digit ranges
  function automatic logic [7:0] non_hex_char();
    case ($urandom_range(0, 4))
      0: return 8'(8'h67 + $urandom_range(0, 19));
      1: return CH_PERCENT;
      2: return CH_PLUS;
      3: return 8'($urandom_range(128, 255));
      default: begin
        case ($urandom_range(0, 4))
          0:       return 8'h2F;
          1:       return 8'h3A;
          2:       return 8'h40;
          3:       return 8'h47;
          default: return 8'h60;
        endcase
      end
    endcase
  endfunction

  // valid stays high after the transfer so a gapless next item follows directly
  task automatic send_item(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap(gapless);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_byte       = b;
    end_of_string = fin;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
    if (fin) strings++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // sender pauses until every predicted result is out, then lets dropped work finish
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_DATA_W-1:0] v);
    drain();
    cfg_valid    = 1'b1;
    cfg_capacity = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_writes++;
  endtask

  initial begin : receiver
    int   stall;
    logic fast;
    out_ready = 1'b0;
    fast      = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        out_ready = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
      end
      if ($urandom_range(0, 31) == 0) fast = ~fast;
      stall = pick_gap(fast);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int                    directed_n;
    int                    start;
    int                    len;
    logic [CFG_DATA_W-1:0] cap;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_capacity  = '0;
    in_valid      = 1'b0;
    in_byte       = 8'h00;
    end_of_string = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // escapes of both cases, plus, zero and high bytes, broken escapes
    send_text("%41%6f+");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("%4g%%41%g%F");
    send_item(8'hA5, 1'b1);

    // capacity used up: trailing byte dropped, end mark instead of terminator
    write_capacity(16'd2);
    send_text("%41bc");
    send_item(8'h5A, 1'b1);

    // capacity lowered below the count in the middle of a string
    write_capacity(16'hFFFF);
    send_text("xy");
    write_capacity(16'd1);
    send_text("z");
    send_item(8'h00, 1'b1);
    directed_n = sent;

    // receiver holds off while the sender keeps offering a long string
    write_capacity(16'hFFFF);
    hold_req = 1'b1;
    gapless  = 1'b1;
    repeat (24) send_item(8'($urandom_range(8'h30, 8'h7a)), 1'b0);
    send_item(8'h00, 1'b1);
    gapless = 1'b0;

    while (sent < directed_n + RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       cap = '0;
        1:       cap = '1;
        2:       cap = 16'd1;
        3, 4, 5: cap = 16'($urandom_range(2, 12));
        6:       cap = 16'($urandom_range(0, 65535));
        default: cap = 16'($urandom_range(13, 40));
      endcase
      write_capacity(cap);
      repeat ($urandom_range(2, 5)) begin
        gapless = ($urandom_range(0, 3) == 0);
        len     = int'($urandom_range(0, 12));
        start   = sent;
        while (sent - start < len) begin
          if ($urandom_range(0, 23) == 0) write_capacity(16'($urandom_range(0, 8)));
          case ($urandom_range(0, 12))
            0, 1, 2, 3: send_item(8'($urandom_range(8'h20, 8'h7e)), 1'b0);
            4:          send_item(CH_PLUS, 1'b0);
            5, 6: begin
              send_item(CH_PERCENT, 1'b0);
              send_item(hex_char(), 1'b0);
              send_item(hex_char(), 1'b0);
            end
            7: begin
              send_item(CH_PERCENT, 1'b0);
              send_item(hex_char(), 1'b0);
              send_item(non_hex_char(), 1'b0);
            end
            8: begin
              send_item(CH_PERCENT, 1'b0);
              send_item(non_hex_char(), 1'b0);
            end
            9:       send_item(8'($urandom_range(0, 255)), 1'b0);
            10:      send_item(CH_PERCENT, 1'b0);
            11:      send_item(8'($urandom_range(128, 255)), 1'b0);
            default: send_item(8'h00, 1'b0);
          endcase
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    gapless = 1'b0;
    drain();

    $display("tb: %0d character and end transfers in %0d strings, %0d capacity writes",
             sent, strings, cfg_writes);
    $display("tb: %0d results compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/upd_pkg.sv
src/upd_front.sv
src/upd_queue.sv
src/upd_back.sv
src/url_percent_decoder.sv
tb/url_decode_checker.sv
tb/tb_top.sv
